/* rtl/core/mbe_pkg.sv */
package mbe_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // column and row bits inside the label memory
   localparam int CXW    = $clog2(MAX_WIDTH);
   localparam int CYW    = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = CXW + CYW;

   // effective frame size, able to hold the maximum itself
   localparam int SZW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 9;

   localparam logic [CSR_AW-1:0] CSR_DIRECTIONAL = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_OFFSET_X    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_OFFSET_Y    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_FRAME_W     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_FRAME_H     = 3'd4;

   typedef logic [1:0] label_type;

   localparam label_type LBL_NONE   = 2'd0;
   localparam label_type LBL_AREA   = 2'd1;
   localparam label_type LBL_BORDER = 2'd2;

   typedef struct packed {
      logic              directional_mode;
      logic signed [2:0] offset_x;
      logic signed [2:0] offset_y;
      logic [SZW-1:0]    frame_width;
      logic [SZW-1:0]    frame_height;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      label_type         wdata;
   } ram_req_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CXW-1:0] x,
                                                   input logic [CYW-1:0] y);
      return {y, x};
   endfunction

endpackage

/* rtl/core/mask_border_extractor_top.sv */
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser: action; tdata: x_pos, y_pos, label_in
// rsp       out  rsp_tvalid/rsp_tready  tdata: label_out
// csr       in   csr_wr_en              csr_index, csr_wdata
//
// a write needs no further step; a query outside the frame reads nothing; one on a
// none pixel, or on the frame edge in neighbour mode, ends on the centre; the probe
// cell or four neighbours follow, one read per cycle from the single-port label memory.
// reset clears control and configuration only; label memory holds no valid bits.
// a finished result goes to the output register; if that register is still held, the
// result waits in a second register and req_tready stays low until the output drains.
module mask_border_extractor_top
   import mbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // x_pos[7:0], y_pos[15:8], label_in[17:16]
   input  logic [0:0]        req_tuser,   // action[0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // label_out[1:0]
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cfg_type     cfg;
   ram_req_type ram_req;
   label_type   ram_rdata;
   label_type   rsp_label;

   mbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbe_mask_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   mbe_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser[0]),
      .req_x      (req_tdata[7:0]),
      .req_y      (req_tdata[15:8]),
      .req_label  (req_tdata[17:16]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_label  (rsp_label),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata)
   );

   assign rsp_tdata = {6'd0, rsp_label};

endmodule

/* rtl/core/mbe_csr.sv */
module mbe_csr
   import mbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output cfg_type           cfg
);

   function automatic int eff_size(input logic [CSR_DW-1:0] v, input int maxv);
      int r;
      r = int'(v);
      if (r < 1) r = 1;
      if (r > maxv) r = maxv;
      return r;
   endfunction

   logic              dir_ff;
   logic signed [2:0] offx_ff;
   logic signed [2:0] offy_ff;
   logic [SZW-1:0]    fw_ff;
   logic [SZW-1:0]    fh_ff;

   // sizes are stored already clamped to the legal range
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= 1'b0;
         offx_ff <= 3'sd0;
         offy_ff <= 3'sd0;
         fw_ff   <= SZW'(eff_size(CSR_DW'(256), MAX_WIDTH));
         fh_ff   <= SZW'(eff_size(CSR_DW'(256), MAX_HEIGHT));
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIRECTIONAL: dir_ff  <= csr_wdata[0];
            CSR_OFFSET_X:    offx_ff <= signed'(csr_wdata[2:0]);
            CSR_OFFSET_Y:    offy_ff <= signed'(csr_wdata[2:0]);
            CSR_FRAME_W:     fw_ff   <= SZW'(eff_size(csr_wdata, MAX_WIDTH));
            CSR_FRAME_H:     fh_ff   <= SZW'(eff_size(csr_wdata, MAX_HEIGHT));
            default: begin
            end
         endcase
      end
   end

   assign cfg.directional_mode = dir_ff;
   assign cfg.offset_x         = offx_ff;
   assign cfg.offset_y         = offy_ff;
   assign cfg.frame_width      = fw_ff;
   assign cfg.frame_height     = fh_ff;

endmodule

/* rtl/core/mbe_mask_ram.sv */
module mbe_mask_ram
   import mbe_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output label_type   ram_rdata
);

   label_type mem [2**ADDR_W];
   label_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en) begin
         if (ram_req.we) begin
            mem[ram_req.addr] <= ram_req.wdata;
         end else begin
            rdata_ff <= mem[ram_req.addr];
         end
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

/* rtl/core/mbe_seq.sv */
module mbe_seq
   import mbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_x,
   input  logic [7:0]  req_y,
   input  label_type   req_label,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output label_type   rsp_label,
   output ram_req_type ram_req,
   input  label_type   ram_rdata
);

   // step names the read whose data shows on ram_rdata this cycle
   typedef enum logic [2:0] {
      ST_OUTSIDE,
      ST_CENTER,
      ST_LEFT,
      ST_RIGHT,
      ST_UP,
      ST_DOWN,
      ST_PROBE
   } step_type;

   function automatic label_type swap_label(input label_type c);
      return (c == LBL_AREA) ? LBL_BORDER : LBL_AREA;
   endfunction

   logic            busy_ff, busy_in;
   step_type        step_ff, step_in;
   step_type        step_seq;
   logic [CXW-1:0]  x_ff, x_in;
   logic [CYW-1:0]  y_ff, y_in;
   label_type       c_ff, c_in;
   logic            eq_ff, eq_in;
   logic            pend_ff, pend_in;
   label_type       pend_lbl_ff, pend_lbl_in;
   logic            out_valid_ff, out_valid_in;
   label_type       out_lbl_ff, out_lbl_in;

   logic            fin;
   label_type       res;
   logic            nxt_read;
   logic [ADDR_W-1:0] nxt_addr;
   logic            interior;
   logic            in_frame;
   logic            acc;
   logic            out_free;
   logic [CXW-1:0]  probe_x;
   logic [CYW-1:0]  probe_y;

   always_comb begin
      int px;
      int py;
      px = int'(x_ff) + int'(cfg.offset_x);
      py = int'(y_ff) + int'(cfg.offset_y);
      if (px < 0) px = 0;
      if (px > int'(cfg.frame_width) - 1) px = int'(cfg.frame_width) - 1;
      if (py < 0) py = 0;
      if (py > int'(cfg.frame_height) - 1) py = int'(cfg.frame_height) - 1;
      probe_x = CXW'(px);
      probe_y = CYW'(py);
   end

   assign interior = (x_ff != '0) && (int'(x_ff) + 1 < int'(cfg.frame_width)) &&
                     (y_ff != '0) && (int'(y_ff) + 1 < int'(cfg.frame_height));

   assign in_frame = (int'(req_x) < int'(cfg.frame_width)) &&
                     (int'(req_y) < int'(cfg.frame_height));

   // read sequencing and result
   always_comb begin
      fin      = 1'b0;
      res      = LBL_NONE;
      nxt_read = 1'b0;
      nxt_addr = cell_addr(x_ff, y_ff);
      step_seq = step_ff;
      c_in     = c_ff;
      eq_in    = eq_ff;
      if (busy_ff) begin
         unique case (step_ff)
            ST_OUTSIDE: begin
               fin = 1'b1;
            end
            ST_CENTER: begin
               c_in = ram_rdata;
               if (ram_rdata == LBL_NONE) begin
                  fin = 1'b1;
               end else if (cfg.directional_mode) begin
                  nxt_read = 1'b1;
                  nxt_addr = cell_addr(probe_x, probe_y);
                  step_seq = ST_PROBE;
               end else if (interior) begin
                  nxt_read = 1'b1;
                  nxt_addr = cell_addr(x_ff - 1'b1, y_ff);
                  step_seq = ST_LEFT;
                  eq_in    = 1'b1;
               end else begin
                  fin = 1'b1;
                  res = swap_label(ram_rdata);
               end
            end
            ST_LEFT: begin
               eq_in    = eq_ff && (ram_rdata == c_ff);
               nxt_read = 1'b1;
               nxt_addr = cell_addr(x_ff + 1'b1, y_ff);
               step_seq = ST_RIGHT;
            end
            ST_RIGHT: begin
               eq_in    = eq_ff && (ram_rdata == c_ff);
               nxt_read = 1'b1;
               nxt_addr = cell_addr(x_ff, y_ff - 1'b1);
               step_seq = ST_UP;
            end
            ST_UP: begin
               eq_in    = eq_ff && (ram_rdata == c_ff);
               nxt_read = 1'b1;
               nxt_addr = cell_addr(x_ff, y_ff + 1'b1);
               step_seq = ST_DOWN;
            end
            ST_DOWN: begin
               fin = 1'b1;
               res = (eq_ff && (ram_rdata == c_ff)) ? LBL_AREA : swap_label(c_ff);
            end
            ST_PROBE: begin
               fin = 1'b1;
               res = (ram_rdata == LBL_NONE) ? LBL_BORDER : c_ff;
            end
            default: begin
               fin = 1'b1;
            end
         endcase
      end
   end

   // a new item may enter in the cycle the previous query finishes, if its result has room
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = !pend_ff && (!busy_ff || (fin && out_free));
   assign acc       = req_valid && req_ready;

   always_comb begin
      ram_req.en    = nxt_read;
      ram_req.we    = 1'b0;
      ram_req.addr  = nxt_addr;
      ram_req.wdata = (req_label == 2'd3) ? LBL_BORDER : req_label;
      busy_in       = busy_ff && !fin;
      step_in       = step_seq;
      x_in          = x_ff;
      y_in          = y_ff;
      if (acc) begin
         ram_req.addr = cell_addr(CXW'(req_x), CYW'(req_y));
         ram_req.en   = in_frame;
         ram_req.we   = !req_action;
         busy_in      = req_action;
         x_in         = CXW'(req_x);
         y_in         = CYW'(req_y);
         step_in      = in_frame ? ST_CENTER : ST_OUTSIDE;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_lbl_in   = out_lbl_ff;
      pend_in      = pend_ff;
      pend_lbl_in  = pend_lbl_ff;
      if (pend_ff && out_free) begin
         out_valid_in = 1'b1;
         out_lbl_in   = pend_lbl_ff;
         pend_in      = 1'b0;
      end else if (fin && out_free) begin
         out_valid_in = 1'b1;
         out_lbl_in   = res;
      end else if (fin) begin
         pend_in     = 1'b1;
         pend_lbl_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ST_OUTSIDE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      c_ff        <= c_in;
      eq_ff       <= eq_in;
      pend_lbl_ff <= pend_lbl_in;
      out_lbl_ff  <= out_lbl_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_label = out_lbl_ff;

endmodule

/* rtl/core/mbe_checker.sv */
module mbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled response dropped");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled response changed");

   // only none, area or border leave the block, with zero padding
   a_legal_label: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[7:2] == 6'd0))
      else $error("illegal response label");

endmodule

bind mask_border_extractor_top mbe_checker u_mbe_checker (.*);
